/* src/ouis_pkg.sv */
// ----------------------------------------------------------------------------
// ouis_pkg
// Shared types and constants for the insertion-ordered unique ID set.
// ----------------------------------------------------------------------------
package ouis_pkg;

  localparam int CAPACITY = 16;
  localparam int ID_W     = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    FN_INS  = 2'd0,
    FN_DEL  = 2'd1,
    FN_LIST = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_NOTFOUND = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_EMPTY    = 3'd4
  } stat_t;

  typedef enum logic [2:0] {
    CELL_IDLE,
    CELL_CMP,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC,
    ST_LIST
  } state_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] id_value;
  } in_item_t;

  typedef struct packed {
    stat_t       status;
    logic [31:0] out_id;
    logic        last;
    logic [4:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    cell_cmd_t         cmd;
    logic [ID_W-1:0]   key;
    logic [CNT_W-1:0]  count;
  } cell_ctrl_t;

endpackage

/* src/ouis_cell.sv */
// ----------------------------------------------------------------------------
// ouis_cell
// One storage cell of the set: holds an entry, compares it with the key,
// and shifts or rotates entries with its neighbors.
// ----------------------------------------------------------------------------
module ouis_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ouis_pkg::cell_ctrl_t     ctrl,
  input  logic [ouis_pkg::IDX_W-1:0] cell_idx,
  input  logic [ouis_pkg::ID_W-1:0]  next_entry,
  input  logic [ouis_pkg::ID_W-1:0]  head_entry,
  input  logic                     hit_in,
  output logic [ouis_pkg::ID_W-1:0]  entry,
  output logic                     hit_out
);
  import ouis_pkg::*;

  logic [ID_W-1:0]  entry_r, entry_nxt;
  logic             hit_r, hit_nxt;
  logic [CNT_W-1:0] pos;
  logic             valid;
  logic             is_tail;

  assign pos     = CNT_W'(cell_idx);
  assign valid   = pos < ctrl.count;
  assign is_tail = pos == (ctrl.count - CNT_W'(1));

  always_comb begin
    entry_nxt = entry_r;
    hit_nxt   = hit_r;
    case (ctrl.cmd)
      CELL_CMP: begin
        hit_nxt = valid && (entry_r == ctrl.key);
      end
      CELL_INS: begin
        if (pos == ctrl.count) begin
          entry_nxt = ctrl.key;
        end
      end
      CELL_DEL: begin
        // close up behind the matching entry
        if (hit_in || hit_r) begin
          entry_nxt = next_entry;
        end
        hit_nxt = 1'b0;
      end
      CELL_ROT: begin
        if (is_tail) begin
          entry_nxt = head_entry;
        end else if (valid) begin
          entry_nxt = next_entry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign entry   = entry_r;
  assign hit_out = hit_in | hit_r;

endmodule

/* src/ordered_unique_id_set.sv */
// ----------------------------------------------------------------------------
// ordered_unique_id_set
// Insertion-ordered set of distinct IDs built as a chain of storage cells.
// ----------------------------------------------------------------------------
// Insert and remove: busy through a compare state, then an update state; the
// result strobes in the cycle after the update state.
// List: busy while the chain rotates, one result per entry per cycle;
// an empty list never raises busy and strobes the next cycle.
// A new item may start while the last result is on the ports. Sync reset
// empties the set and clears invalid_id; the receiver cannot stall results.
module ordered_unique_id_set (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ouis_pkg::in_item_t   in_data,
  output logic                 out_valid,
  output ouis_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata
);
  import ouis_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] list_idx_r, list_idx_nxt;
  func_t            func_r;
  logic [ID_W-1:0]  key_r;
  logic [ID_W-1:0]  invalid_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;
  cell_ctrl_t       cell_ctrl;
  cell_cmd_t        cmd;
  logic             accept;

  logic [ID_W-1:0]  entry_w [CAPACITY];
  logic             chain_w [CAPACITY+1];

  assign accept = start && !busy;
  assign busy   = state_r != ST_IDLE;

  assign cell_ctrl.cmd   = cmd;
  assign cell_ctrl.key   = key_r;
  assign cell_ctrl.count = count_r;
  assign chain_w[0]      = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ouis_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (cell_ctrl),
      .cell_idx   (IDX_W'(i)),
      .next_entry (entry_w[(i + 1 < CAPACITY) ? i + 1 : i]),
      .head_entry (entry_w[0]),
      .hit_in     (chain_w[i]),
      .entry      (entry_w[i]),
      .hit_out    (chain_w[i+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    list_idx_nxt  = list_idx_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    cmd           = CELL_IDLE;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.func)
            FN_INS, FN_DEL: begin
              state_nxt = ST_CMP;
            end
            FN_LIST: begin
              list_idx_nxt = '0;
              if (count_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_nxt.status      = STAT_EMPTY;
                out_nxt.out_id      = '0;
                out_nxt.last        = 1'b1;
                out_nxt.entry_count = 5'(count_r);
              end else begin
                state_nxt = ST_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CMP: begin
        cmd       = CELL_CMP;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt      = ST_IDLE;
        out_valid_nxt  = 1'b1;
        out_nxt.out_id = '0;
        out_nxt.last   = 1'b1;
        if (func_r == FN_INS) begin
          if ((key_r == invalid_r) || chain_w[CAPACITY]) begin
            out_nxt.status = STAT_DUP;
          end else if (count_r == CNT_W'(CAPACITY)) begin
            out_nxt.status = STAT_FULL;
          end else begin
            cmd            = CELL_INS;
            count_nxt      = count_r + CNT_W'(1);
            out_nxt.status = STAT_OK;
          end
        end else begin
          if (chain_w[CAPACITY]) begin
            cmd            = CELL_DEL;
            count_nxt      = count_r - CNT_W'(1);
            out_nxt.status = STAT_OK;
          end else begin
            out_nxt.status = STAT_NOTFOUND;
          end
        end
        out_nxt.entry_count = 5'(count_nxt);
      end
      ST_LIST: begin
        cmd                 = CELL_ROT;
        out_valid_nxt       = 1'b1;
        out_nxt.status      = STAT_OK;
        out_nxt.out_id      = 32'(entry_w[0]);
        out_nxt.last        = list_idx_r == (count_r - CNT_W'(1));
        out_nxt.entry_count = 5'(count_r);
        list_idx_nxt        = list_idx_r + CNT_W'(1);
        if (out_nxt.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      list_idx_r  <= '0;
      invalid_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      list_idx_r  <= list_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        invalid_r <= cfg_wdata[ID_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (accept) begin
      func_r <= in_data.func;
      key_r  <= in_data.id_value[ID_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == STAT_FULL) |-> count_r == CNT_W'(CAPACITY))
    else $error("full status while set not full");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == STAT_EMPTY) |-> (count_r == '0) && out_r.last)
    else $error("empty status with stored entries");

  a_list_enter: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.func == FN_LIST) && (count_r != '0) |=> state_r == ST_LIST)
    else $error("list of nonempty set did not start");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |=> out_valid_r && out_r.last && (state_r == ST_IDLE))
    else $error("insert or remove without a single final result");
`endif

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives ordered_unique_id_set with a directed sequence and then random
// phases, each under its own invalid ID. A shadow copy of the ID set predicts
// every result, and each strobed result is checked in order against it.
// ----------------------------------------------------------------------------
module testbench;
  import ouis_pkg::*;

  class id_set_tracker;
    logic [31:0] ids [CAPACITY];
    int          count;
    logic [31:0] invalid_id;
    out_item_t   pending_results [$];
    int          mismatches;

    function new();
      count      = 0;
      invalid_id = '0;
      mismatches = 0;
    endfunction

    function void set_invalid(logic [31:0] value);
      invalid_id = value;
    endfunction

    function int locate(logic [31:0] key);
      for (int i = 0; i < count; i++) begin
        if (ids[i] == key) return i;
      end
      return -1;
    endfunction

    function void queue_result(stat_t st, logic [31:0] id, logic lst);
      out_item_t r;
      r.status      = st;
      r.out_id      = id;
      r.last        = lst;
      r.entry_count = 5'(count);
      pending_results.push_back(r);
    endfunction

    function void note_command(in_item_t cmd);
      int          pos;
      logic [31:0] key;
      key = cmd.id_value;
      case (cmd.func)
        FN_INS: begin
          if (key == invalid_id || locate(key) >= 0) begin
            queue_result(STAT_DUP, '0, 1'b1);
          end else if (count >= CAPACITY) begin
            queue_result(STAT_FULL, '0, 1'b1);
          end else begin
            ids[count] = key;
            count++;
            queue_result(STAT_OK, '0, 1'b1);
          end
        end
        FN_DEL: begin
          pos = locate(key);
          if (pos < 0) begin
            queue_result(STAT_NOTFOUND, '0, 1'b1);
          end else begin
            for (int i = pos; i + 1 < count; i++) ids[i] = ids[i + 1];
            count--;
            queue_result(STAT_OK, '0, 1'b1);
          end
        end
        FN_LIST: begin
          if (count == 0) begin
            queue_result(STAT_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < count; i++) queue_result(STAT_OK, ids[i], i + 1 == count);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what, out_item_t got, out_item_t want);
      mismatches++;
      if (mismatches <= 40)
        $display("%s: got st=%0d id=%h last=%0b cnt=%0d, want st=%0d id=%h last=%0b cnt=%0d",
                 what, got.status, got.out_id, got.last, got.entry_count,
                 want.status, want.out_id, want.last, want.entry_count);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        want = '0;
        report("unexpected result", got, want);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.out_id !== want.out_id ||
            got.last !== want.last || got.entry_count !== want.entry_count)
          report("result mismatch", got, want);
      end
    endtask
  endclass

  localparam int LIMIT     = 400000;
  localparam int PHASES    = 6;
  localparam int PER_PHASE = 74;
  localparam int POOL      = 24;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_data = '0;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  id_set_tracker tracker;
  logic [31:0]   id_pool [POOL];
  int unsigned   cycles = 0;

  ordered_unique_id_set dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_result(out_data);
  end

  // called right after a rising edge; returns at the edge of the transfer
  task automatic send(in_item_t cmd);
    start   <= 1'b1;
    in_data <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_command(cmd);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic idle_gap(bit burst);
    int g;
    g = burst ? 0 : gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_results();
    start <= 1'b0;
    do @(posedge clk); while (tracker.pending_results.size() != 0 || busy);
  endtask

  task automatic drain();
    wait_results();
    repeat (6) @(posedge clk);
  endtask

  task automatic write_invalid(logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.set_invalid(value);
  endtask

  task automatic issue(func_t f, logic [31:0] id);
    in_item_t cmd;
    cmd.func     = f;
    cmd.id_value = id;
    send(cmd);
    idle_gap(1'b0);
  endtask

  function automatic func_t pick_func(int ins_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_w) return FN_INS;
    if (r < 88) return FN_DEL;
    if (r < 97) return FN_LIST;
    return FN_NONE;
  endfunction

  function automatic logic [31:0] pick_id(func_t f);
    int r;
    r = $urandom_range(0, 99);
    if (f == FN_DEL && tracker.count > 0 && r < 45)
      return tracker.ids[$urandom_range(0, tracker.count - 1)];
    if (r < 85) return id_pool[$urandom_range(0, POOL - 1)];
    if (r < 92) return tracker.invalid_id;
    return $urandom;
  endfunction

  task automatic fill_pool();
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int k = 2; k < POOL; k++)
      id_pool[k] = ($urandom_range(0, 3) == 0) ? 32'(k) : $urandom;
  endtask

  task automatic run_phase(int phase);
    int          done;
    int          ins_w;
    bit          burst;
    logic [31:0] inv;
    in_item_t    cmd;
    done  = 0;
    ins_w = 40 + 15 * (phase % 3);
    burst = (phase == 2) || ($urandom_range(0, 3) == 0);
    fill_pool();
    case (phase)
      0:       inv = '1;
      1:       inv = $urandom;
      2:       inv = '0;
      3:       inv = (tracker.count > 0) ? tracker.ids[$urandom_range(0, tracker.count - 1)]
                                         : id_pool[5];
      4:       inv = 32'h8000_0000;
      default: inv = id_pool[$urandom_range(0, POOL - 1)];
    endcase
    drain();
    write_invalid(inv);
    while (done < PER_PHASE) begin
      cmd.func     = pick_func(ins_w);
      cmd.id_value = pick_id(cmd.func);
      send(cmd);
      if (cmd.func != FN_NONE) done++;
      if (!burst && (done == 30 || $urandom_range(0, 24) == 0)) wait_results();
      else idle_gap(burst);
    end
  endtask

  initial begin
    tracker = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(FN_LIST, 32'h0);
    issue(FN_INS, 32'h0);
    issue(FN_INS, 32'hFFFF_FFFF);
    issue(FN_NONE, 32'hFFFF_FFFF);
    issue(FN_DEL, 32'h0);
    for (int i = 0; i < 15; i++) issue(FN_INS, 32'h1 << (2 * i));
    issue(FN_INS, 32'h5555_5555);
    issue(FN_INS, 32'h1);
    issue(FN_LIST, 32'hFFFF_FFFF);
    issue(FN_DEL, 32'hFFFF_FFFF);
    issue(FN_DEL, 32'h1000_0000);
    // invalid ID now equals a stored entry
    drain();
    write_invalid(32'h0000_0010);
    issue(FN_INS, 32'h0000_0010);
    issue(FN_DEL, 32'h0000_0010);
    issue(FN_LIST, 32'h0);

    for (int p = 0; p < PHASES; p++) run_phase(p);

    wait_results();
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

/* ordered_unique_id_set.f */
src/ouis_pkg.sv
src/ouis_cell.sv
src/ordered_unique_id_set.sv
bench/testbench.sv
